/* hw/rtl/cps_pkg.sv */
// types, constants and register codes shared by the converter protection supervisor
package cps_pkg;

   localparam int TICK_WIDTH      = 24;
   localparam int TIMEOUT_WIDTH   = 24;
   localparam int FAULT_WIDTH     = 10;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;
   // width for comparing the tick counter with the timeout
   localparam int CMP_WIDTH       = (TICK_WIDTH > TIMEOUT_WIDTH) ? TICK_WIDTH : TIMEOUT_WIDTH;

   // operating modes
   typedef enum logic [2:0] {
      MODE_OFF       = 3'd0,
      MODE_PRECHARGE = 3'd1,
      MODE_READY     = 3'd2,
      MODE_RUN       = 3'd3,
      MODE_FAULT     = 3'd4
   } mode_type;

   // fault bit positions
   localparam int FLT_ESTOP      = 0;
   localparam int FLT_HWTRIP     = 1;
   localparam int FLT_SENSOR     = 2;
   localparam int FLT_DEADLINE   = 3;
   localparam int FLT_OV         = 4;
   localparam int FLT_UV         = 5;
   localparam int FLT_DCOC       = 6;
   localparam int FLT_GRIDOC     = 7;
   localparam int FLT_OT         = 8;
   localparam int FLT_PC_TIMEOUT = 9;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OV_TRIP     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UV_TRIP     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DCOC_TRIP   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRIDOC_TRIP = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OT_TRIP     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DONE_LEVEL  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIMEOUT     = 3'd6;

   // register reset values
   localparam logic [15:0]              RST_OV_TRIP     = 16'd15360;
   localparam logic [15:0]              RST_UV_TRIP     = 16'd10240;
   localparam logic [15:0]              RST_DCOC_TRIP   = 16'd2560;
   localparam logic [15:0]              RST_GRIDOC_TRIP = 16'd2560;
   localparam logic [15:0]              RST_OT_TRIP     = 16'd1440;
   localparam logic [15:0]              RST_DONE_LEVEL  = 16'd11264;
   localparam logic [TIMEOUT_WIDTH-1:0] RST_TIMEOUT     = 24'd1000;

   typedef struct packed {
      logic        estop;
      logic        hw_trip;
      logic        sensor_bad;
      logic        deadline_miss;
      logic [15:0] bus_voltage;
      logic [15:0] bus_current;
      logic [15:0] line_current;
      logic [15:0] peak_temperature;
      logic        start_req;
      logic        clear_req;
      logic        grid_lock;
   } sample_type;

   typedef struct packed {
      logic [15:0]              ov_trip;
      logic [15:0]              uv_trip;
      logic [15:0]              dcoc_trip;
      logic [15:0]              gridoc_trip;
      logic [15:0]              ot_trip;
      logic [15:0]              done_level;
      logic [TIMEOUT_WIDTH-1:0] timeout;
   } cfg_type;

   typedef struct packed {
      mode_type               mode;
      logic [FAULT_WIDTH-1:0] faults;
      logic [TICK_WIDTH-1:0]  ticks;
   } state_type;

   typedef struct packed {
      mode_type               mode;
      logic [FAULT_WIDTH-1:0] fault_bits;
      logic                   precharge_relay_on;
      logic                   contactor_on;
      logic                   pwm_on;
   } result_type;

endpackage

/* hw/rtl/cps_eval.sv */
// one tick of fault checking and mode sequencing
module cps_eval (
   input  cps_pkg::sample_type smp,
   input  cps_pkg::cfg_type    cfg,
   input  cps_pkg::state_type  cur,
   output cps_pkg::state_type  nxt,
   output cps_pkg::result_type res
);
   import cps_pkg::*;

   logic [16:0]            ibus_mag;
   logic [16:0]            iline_mag;
   logic [FAULT_WIDTH-1:0] act;
   logic [TICK_WIDTH-1:0]  tick_inc;
   logic                   timed_out;
   logic                   enter;
   mode_type               mode_nxt;
   logic [FAULT_WIDTH-1:0] faults_nxt;

   // magnitude of a two's complement sample, -32768 gives 32768
   assign ibus_mag  = smp.bus_current[15] ?
                      (17'd0 - {1'b1, smp.bus_current}) : {1'b0, smp.bus_current};
   assign iline_mag = smp.line_current[15] ?
                      (17'd0 - {1'b1, smp.line_current}) : {1'b0, smp.line_current};

   assign tick_inc  = (cur.ticks == '1) ? cur.ticks : cur.ticks + 1'b1;
   assign timed_out = CMP_WIDTH'(tick_inc) >= CMP_WIDTH'(cfg.timeout);

   always_comb begin
      act                 = '0;
      act[FLT_ESTOP]      = smp.estop;
      act[FLT_HWTRIP]     = smp.hw_trip;
      act[FLT_SENSOR]     = smp.sensor_bad;
      act[FLT_DEADLINE]   = smp.deadline_miss;
      act[FLT_OV]         = smp.bus_voltage > cfg.ov_trip;
      act[FLT_UV]         = (cur.mode == MODE_RUN) && (smp.bus_voltage < cfg.uv_trip);
      act[FLT_DCOC]       = ibus_mag > {1'b0, cfg.dcoc_trip};
      act[FLT_GRIDOC]     = iline_mag > {1'b0, cfg.gridoc_trip};
      act[FLT_OT]         = $signed(smp.peak_temperature) > $signed(cfg.ot_trip);
   end

   always_comb begin
      mode_nxt   = cur.mode;
      faults_nxt = cur.faults;
      enter      = 1'b0;
      if (act != '0) begin
         faults_nxt = cur.faults | act;
         mode_nxt   = MODE_FAULT;
         enter      = 1'b1;
      end else begin
         case (cur.mode)
            MODE_OFF: begin
               if (smp.start_req) begin
                  mode_nxt = MODE_PRECHARGE;
                  enter    = 1'b1;
               end
            end
            MODE_PRECHARGE: begin
               if (!smp.start_req) begin
                  mode_nxt = MODE_OFF;
                  enter    = 1'b1;
               end else if (smp.bus_voltage >= cfg.done_level) begin
                  mode_nxt = MODE_READY;
                  enter    = 1'b1;
               end else if (timed_out) begin
                  faults_nxt[FLT_PC_TIMEOUT] = 1'b1;
                  mode_nxt = MODE_FAULT;
                  enter    = 1'b1;
               end
            end
            MODE_READY: begin
               if (!smp.start_req) begin
                  mode_nxt = MODE_OFF;
                  enter    = 1'b1;
               end else if (smp.grid_lock) begin
                  mode_nxt = MODE_RUN;
                  enter    = 1'b1;
               end
            end
            MODE_RUN: begin
               if (!smp.start_req || !smp.grid_lock) begin
                  mode_nxt = MODE_READY;
                  enter    = 1'b1;
               end
            end
            MODE_FAULT: begin
               if (smp.clear_req && !smp.start_req) begin
                  faults_nxt = '0;
                  mode_nxt   = MODE_OFF;
                  enter      = 1'b1;
               end
            end
            default: begin
               // corrupted mode register
               faults_nxt[FLT_HWTRIP] = 1'b1;
               mode_nxt = MODE_FAULT;
               enter    = 1'b1;
            end
         endcase
      end
   end

   assign nxt.mode   = mode_nxt;
   assign nxt.faults = faults_nxt;
   assign nxt.ticks  = enter ? '0 : tick_inc;

   assign res.mode               = mode_nxt;
   assign res.fault_bits         = faults_nxt;
   assign res.precharge_relay_on = mode_nxt == MODE_PRECHARGE;
   assign res.contactor_on       = mode_nxt inside {MODE_READY, MODE_RUN};
   assign res.pwm_on             = (mode_nxt == MODE_RUN) && (faults_nxt == '0);

endmodule

/* hw/rtl/converter_protection_supervisor.sv */
// converter protection supervisor top level: input stage, state, result stage and registers
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    flags, bus and line measurements, requests
//   rsp      out        rsp_valid/stall    mode, latched faults, relay/contactor/pwm
//   csr      in         csr_valid/ready    register index and write data
//
// one tick per cycle sustained while rsp_stall is low; a tick is registered in the input stage and
// is then evaluated into the result register
// the state (mode, fault latch, tick counter) updates as a tick moves into the
// result register, so each tick sees the state its predecessor left
// reset is synchronous and returns the mode to off, clears faults and counter
// and reloads the trip levels, done level and timeout with their defaults
// rsp_stall holds the result register; req_stall rises only while a tick is
// waiting in the input stage behind a stalled result
module converter_protection_supervisor (
   input  logic                                clock,
   input  logic                                reset,
   // tick input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_estop,
   input  logic                                req_hw_trip,
   input  logic                                req_sensor_bad,
   input  logic                                req_deadline_miss,
   input  logic [15:0]                         req_bus_voltage,
   input  logic signed [15:0]                  req_bus_current,
   input  logic signed [15:0]                  req_line_current,
   input  logic signed [15:0]                  req_peak_temperature,
   input  logic                                req_start_req,
   input  logic                                req_clear_req,
   input  logic                                req_grid_lock,
   // tick result
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_mode,
   output logic [cps_pkg::FAULT_WIDTH-1:0]     rsp_fault_bits,
   output logic                                rsp_precharge_relay_on,
   output logic                                rsp_contactor_on,
   output logic                                rsp_pwm_on,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cps_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import cps_pkg::*;

   // input stage
   logic       s1_valid_ff;
   logic       s1_valid_in;
   sample_type s1_smp_ff;
   sample_type req_smp;

   // supervisor state and trip levels
   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;

   // result stage
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   result_type eval_res;

   logic       out_load;
   logic       req_accept;
   logic       csr_write;

   assign req_smp = '{
      estop:            req_estop,
      hw_trip:          req_hw_trip,
      sensor_bad:       req_sensor_bad,
      deadline_miss:    req_deadline_miss,
      bus_voltage:      req_bus_voltage,
      bus_current:      req_bus_current,
      line_current:     req_line_current,
      peak_temperature: req_peak_temperature,
      start_req:        req_start_req,
      clear_req:        req_clear_req,
      grid_lock:        req_grid_lock
   };

   // a waiting tick moves on when the result register is empty or being drained
   assign out_load    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !out_load;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   cps_eval u_eval (
      .smp (s1_smp_ff),
      .cfg (cfg_ff),
      .cur (state_ff),
      .nxt (state_in),
      .res (eval_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_smp_ff <= req_smp;
      end
      if (out_load) begin
         rsp_ff <= eval_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode   <= MODE_OFF;
         state_ff.faults <= '0;
         state_ff.ticks  <= '0;
      end else if (out_load) begin
         state_ff <= state_in;
      end
   end

   // register file, always ready
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ov_trip     <= RST_OV_TRIP;
         cfg_ff.uv_trip     <= RST_UV_TRIP;
         cfg_ff.dcoc_trip   <= RST_DCOC_TRIP;
         cfg_ff.gridoc_trip <= RST_GRIDOC_TRIP;
         cfg_ff.ot_trip     <= RST_OT_TRIP;
         cfg_ff.done_level  <= RST_DONE_LEVEL;
         cfg_ff.timeout     <= RST_TIMEOUT;
      end else if (csr_write) begin
         case (csr_index)
            REG_OV_TRIP:     cfg_ff.ov_trip     <= csr_data[15:0];
            REG_UV_TRIP:     cfg_ff.uv_trip     <= csr_data[15:0];
            REG_DCOC_TRIP:   cfg_ff.dcoc_trip   <= csr_data[15:0];
            REG_GRIDOC_TRIP: cfg_ff.gridoc_trip <= csr_data[15:0];
            REG_OT_TRIP:     cfg_ff.ot_trip     <= csr_data[15:0];
            REG_DONE_LEVEL:  cfg_ff.done_level  <= csr_data[15:0];
            REG_TIMEOUT:     cfg_ff.timeout     <= csr_data[TIMEOUT_WIDTH-1:0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_mode               = rsp_ff.mode;
   assign rsp_fault_bits         = rsp_ff.fault_bits;
   assign rsp_precharge_relay_on = rsp_ff.precharge_relay_on;
   assign rsp_contactor_on       = rsp_ff.contactor_on;
   assign rsp_pwm_on             = rsp_ff.pwm_on;

   // latched faults only ever coexist with the fault mode
   a_fault_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff.faults != '0) |-> (state_ff.mode == MODE_FAULT))
      else $error("fault latch set outside fault mode");

   // timeout fault can only be raised from precharge
   a_timeout_src: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff.faults[FLT_PC_TIMEOUT]) |-> ($past(state_ff.mode) == MODE_PRECHARGE))
      else $error("precharge timeout latched outside precharge");

   // every mode change restarts the tick counter
   a_tick_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode != $past(state_ff.mode)) |-> (state_ff.ticks == '0))
      else $error("tick counter not cleared on mode change");

   // state only moves when a transaction enters the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(state_ff))
      else $error("state changed without a tick");

   // pwm never enabled with a fault pending in the result
   a_pwm_safe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pwm_on) |-> (rsp_fault_bits == '0 && rsp_mode == MODE_RUN))
      else $error("pwm enabled while faulted or not running");

endmodule
